FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/osbv_pkg.sv
package osbv_pkg;

    localparam int STORE_BYTES = 8192;
    localparam int MAX_OPENS   = 255;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int POS_W       = $clog2(STORE_BYTES + 1);
    localparam int CNT_W       = $clog2(MAX_OPENS + 1);
    localparam int UID_W       = 16;

    typedef enum logic [2:0] {
        CMD_OPEN  = 3'd0,
        CMD_CLOSE = 3'd1,
        CMD_GRANT = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WRITE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DENIED  = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]       command;
        logic [UID_W-1:0] requester_uid;
        logic             want_read;
        logic             want_write;
        logic [UID_W-1:0] new_owner_uid;
        logic [7:0]       write_data;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
    } out_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

endpackage

FILE: hw/rtl/osbv_ctrl.sv
module osbv_ctrl
    import osbv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output ctrl_t ctrl
);

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy         = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                ctrl.capture = start;
            end
            FSM_EXEC:
            begin
                busy         = 1'b1;
                ctrl.execute = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/osbv_datapath.sv
module osbv_datapath
    import osbv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  in_t   item,
    output out_t  result
);

    logic [7:0]       store_mem [STORE_BYTES];
    in_t              item_reg;
    logic [7:0]       rd_data_reg;

    logic             owned_reg,  owned_next;
    logic [UID_W-1:0] owner_reg,  owner_next;
    logic             keep_reg,   keep_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [POS_W-1:0] fill_reg,   fill_next;
    logic [POS_W-1:0] drain_reg,  drain_next;

    logic             mem_we;
    logic [CNT_W-1:0] count_up;
    logic [CNT_W-1:0] count_dn;
    status_t          status;
    logic [7:0]       rdata;

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg    <= item;
            rd_data_reg <= store_mem[drain_reg[ADDR_W-1:0]];
        end
        if (mem_we)
        begin
            store_mem[fill_reg[ADDR_W-1:0]] <= item_reg.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg <= 1'b0;
            owner_reg <= '0;
            keep_reg  <= 1'b0;
            count_reg <= '0;
            fill_reg  <= '0;
            drain_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            owned_reg <= owned_next;
            owner_reg <= owner_next;
            keep_reg  <= keep_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            drain_reg <= drain_next;
        end
    end

    assign count_up = (count_reg < CNT_W'(MAX_OPENS)) ? count_reg + 1'b1 : count_reg;
    assign count_dn = (count_reg != '0) ? count_reg - 1'b1 : count_reg;

    always_comb
    begin
        owned_next = owned_reg;
        owner_next = owner_reg;
        keep_next  = keep_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        drain_next = drain_reg;
        mem_we     = 1'b0;
        status     = ST_OK;
        rdata      = '0;
        case (cmd_t'(item_reg.command))
            CMD_OPEN:
            begin
                if (!owned_reg)
                begin
                    if (item_reg.want_read && item_reg.want_write)
                    begin
                        status = ST_DENIED;
                    end
                    else
                    begin
                        keep_next  = item_reg.want_write;
                        owner_next = item_reg.requester_uid;
                        owned_next = 1'b1;
                        count_next = count_up;
                    end
                end
                else if (item_reg.want_write)
                begin
                    status = ST_NOSPACE;
                end
                else if (item_reg.requester_uid != owner_reg)
                begin
                    status = ST_DENIED;
                end
                else
                begin
                    keep_next  = 1'b0;
                    count_next = count_up;
                end
            end
            CMD_CLOSE:
            begin
                count_next = count_dn;
                if (count_dn == '0 && !keep_reg)
                begin
                    owned_next = 1'b0;
                    owner_next = '0;
                    fill_next  = '0;
                    drain_next = '0;
                end
            end
            CMD_GRANT:
            begin
                owner_next = item_reg.new_owner_uid;
            end
            CMD_READ:
            begin
                if (drain_reg < fill_reg)
                begin
                    rdata      = rd_data_reg;
                    drain_next = drain_reg + 1'b1;
                end
                else
                begin
                    status = ST_EMPTY;
                end
            end
            CMD_WRITE:
            begin
                if (fill_reg < POS_W'(STORE_BYTES))
                begin
                    mem_we    = ctrl.execute;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    status = ST_NOSPACE;
                end
            end
            default:
            begin
                status = ST_DENIED;
            end
        endcase
    end

    assign result.status    = status;
    assign result.read_data = rdata;

endmodule

FILE: hw/rtl/owned_secret_byte_vault.sv
// Single-slot owned secret store. An item is taken when start is high and busy
// low; busy then stays high for one cycle, and in that cycle done is high and
// result holds the answer; no new item is taken while busy is high. The busy
// cycle comes from the registered read of the byte store. The receiver cannot
// stall: result is valid only in the cycle in which done is high.
module owned_secret_byte_vault
    import osbv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic done,
    output out_t result
);

    ctrl_t ctrl;

    osbv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    osbv_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

    assign done = ctrl.execute;

endmodule

FILE: hw/rtl/osbv_checker.sv
`include "assert_macros.svh"

module osbv_checker
    import osbv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input in_t  item,
    input logic done,
    input out_t result
);

    `ASSERT_NEXT(a_accept_done, clk, rst_n, start && !busy, done)
    `ASSERT_SAME(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)
    `ASSERT_SAME(a_data_ok, clk, rst_n, done && result.read_data != 8'd0, result.status == ST_OK)
    `ASSERT_NEXT(a_bad_cmd, clk, rst_n, start && !busy && item.command > CMD_WRITE,
                 result.status == ST_DENIED)

endmodule

bind owned_secret_byte_vault osbv_checker u_osbv_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
